// File: design/assert_macros.svh
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define PGCM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Delayed implication: consequent checked after the antecedent, with the delay taken from argument n.
`define PGCM_ASSERT_DLY(lbl, clk, rst_n, ante, n, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
    else $error("assertion failed");

`endif

// File: design/pgcm_pkg.sv
// Types and constants of the point to grid cell mapper.
package pgcm_pkg;

  typedef enum logic [2:0] {
    RC_KEPT    = 3'd0,
    RC_NEAR    = 3'd1,
    RC_HEIGHT  = 3'd2,
    RC_FAR     = 3'd3,
    RC_OUTSIDE = 3'd4
  } reject_code_e;

  typedef enum logic [2:0] {
    CFG_CELL_EDGE      = 3'd0,
    CFG_GRID_LEFT      = 3'd1,
    CFG_GRID_TOP       = 3'd2,
    CFG_CELLS_X        = 3'd3,
    CFG_CELLS_Y        = 3'd4,
    CFG_INTENSITY_GAIN = 3'd5,
    CFG_HEIGHT_GAIN    = 3'd6
  } cfg_reg_e;

  localparam logic signed [23:0] NEAR_LIMIT   = 24'sd2;
  localparam logic [48:0]        FAR_LIMIT_SQ = 49'd26214400;

  typedef struct packed {
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic signed [23:0] point_z;
    logic signed [23:0] point_intensity;
    logic               intensity_present;
  } point_t;

  typedef struct packed {
    logic              kept;
    logic [2:0]        reject_code;
    logic [9:0]        cell_col;
    logic [9:0]        cell_row;
    logic [19:0]       cell_index;
    logic signed [7:0] intensity_value;
    logic signed [7:0] height_value;
  } result_t;

endpackage

// File: design/point_to_grid_cell_mapper.sv
// Top level of the point to grid cell mapper.
//
// Takes one lidar point per clock cycle and gives exactly one result per
// point, one point per cycle sustained. busy is always low: the pipeline
// never stalls, since the receiver cannot hold a result off. The cell
// divider resolves one bit of the column and row quotients per stage.
// Write configuration only while no point is in flight.
module point_to_grid_cell_mapper
  import pgcm_pkg::*;
#(
  parameter int MAX_CELLS_PER_AXIS = 1024,
  parameter int MIN_HEIGHT         = 13,
  parameter int MAX_HEIGHT         = 384
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  point_t  point_i,
  output logic    result_valid_o,
  output result_t result_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i
);

`include "assert_macros.svh"

  localparam int QW      = $clog2(MAX_CELLS_PER_AXIS);
  localparam int NW      = QW + 1;
  localparam int CW      = (24 > 16 + QW) ? 24 : 16 + QW;
  localparam int IW      = QW + NW + 1;
  localparam int LATENCY = QW + 4;

  // Configuration registers
  logic [15:0]        cell_edge_q;
  logic signed [23:0] grid_left_q, grid_top_q;
  logic [10:0]        cells_x_q, cells_y_q;
  logic signed [15:0] intensity_gain_q, height_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_edge_q      <= 16'd128;
      grid_left_q      <= -24'sd2560;
      grid_top_q       <= 24'sd2560;
      cells_x_q        <= 11'd40;
      cells_y_q        <= 11'd40;
      intensity_gain_q <= 16'sd256;
      height_gain_q    <= 16'sd256;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CELL_EDGE:      cell_edge_q      <= cfg_data_i[15:0];
        CFG_GRID_LEFT:      grid_left_q      <= cfg_data_i;
        CFG_GRID_TOP:       grid_top_q       <= cfg_data_i;
        CFG_CELLS_X:        cells_x_q        <= cfg_data_i[10:0];
        CFG_CELLS_Y:        cells_y_q        <= cfg_data_i[10:0];
        CFG_INTENSITY_GAIN: intensity_gain_q <= cfg_data_i[15:0];
        CFG_HEIGHT_GAIN:    height_gain_q    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Value times Q8.8 gain, truncated toward zero, saturated to int8.
  function automatic logic signed [7:0] sat8(input logic signed [39:0] p);
    logic [39:0] mag;
    logic [23:0] q;
    mag = p[39] ? 40'(-p) : 40'(p);
    q   = mag[39:16];
    if (!p[39]) begin
      return (q > 24'd127) ? 8'sd127 : q[7:0];
    end else begin
      return (q > 24'd128) ? 8'sh80 : 8'(24'd0 - q);
    end
  endfunction

  // Stage 1: capture the transaction.
  logic   v1_q;
  point_t p1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else         v1_q <= start && !busy;
  end

  always_ff @(posedge clk_i) begin
    p1_q <= point_i;
  end

  // Stage 2: early rejects, squares, gain products, grid offsets.
  logic               v2_q;
  reject_code_e       code2_q;
  logic signed [47:0] xx_q, yy_q;
  logic signed [39:0] pi_q, ph_q;
  logic signed [24:0] dx_q, dy_q;
  reject_code_e       code2_d;
  logic signed [23:0] inten;

  always_comb begin
    inten = p1_q.intensity_present ? p1_q.point_intensity : 24'sd0;
    if (p1_q.point_x >= -NEAR_LIMIT && p1_q.point_x <= NEAR_LIMIT) begin
      code2_d = RC_NEAR;
    end else if (p1_q.point_z < MIN_HEIGHT || p1_q.point_z > MAX_HEIGHT) begin
      code2_d = RC_HEIGHT;
    end else begin
      code2_d = RC_KEPT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else         v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    code2_q <= code2_d;
    xx_q    <= p1_q.point_x * p1_q.point_x;
    yy_q    <= p1_q.point_y * p1_q.point_y;
    pi_q    <= inten * intensity_gain_q;
    ph_q    <= p1_q.point_z * height_gain_q;
    dx_q    <= 25'(p1_q.point_x) - 25'(grid_left_q);
    dy_q    <= 25'(grid_top_q) - 25'(p1_q.point_y);
  end

  // Stage 3: radius and grid edge checks, saturation, divider operands.
  typedef struct packed {
    reject_code_e      code;
    logic              ovf_x;
    logic              ovf_y;
    logic signed [7:0] iv;
    logic signed [7:0] hv;
  } side_t;

  logic         v3_q;
  side_t        side3_q;
  logic [23:0]  num_x_q, num_y_q;
  side_t        side3_d;
  logic [23:0]  num_x_d, num_y_d;
  logic         far, grid_bad;

  always_comb begin
    far      = (49'(xx_q) + 49'(yy_q)) > FAR_LIMIT_SQ;
    grid_bad = (cell_edge_q == 16'd0) || (dx_q <= 25'sd0) || (dy_q <= 25'sd0);
    num_x_d  = (dx_q > 25'sd0) ? dx_q[23:0] : 24'd0;
    num_y_d  = (dy_q > 25'sd0) ? dy_q[23:0] : 24'd0;
    if (code2_q != RC_KEPT) side3_d.code = code2_q;
    else if (far)           side3_d.code = RC_FAR;
    else if (grid_bad)      side3_d.code = RC_OUTSIDE;
    else                    side3_d.code = RC_KEPT;
    // Quotient would not fit in the divider: beyond the largest grid anyway.
    side3_d.ovf_x = (num_x_d >> QW) >= 24'(cell_edge_q);
    side3_d.ovf_y = (num_y_d >> QW) >= 24'(cell_edge_q);
    side3_d.iv    = sat8(pi_q);
    side3_d.hv    = sat8(ph_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else         v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    side3_q <= side3_d;
    num_x_q <= num_x_d;
    num_y_q <= num_y_d;
  end

  // Divider stages: column and row quotients, side data delayed alongside.
  logic [QW-1:0] col_q, row_q;

  pgcm_divider #(.QW(QW), .CW(CW)) u_div_x (
    .clk_i      (clk_i),
    .dividend_i (num_x_q),
    .divisor_i  (cell_edge_q),
    .quot_o     (col_q)
  );

  pgcm_divider #(.QW(QW), .CW(CW)) u_div_y (
    .clk_i      (clk_i),
    .dividend_i (num_y_q),
    .divisor_i  (cell_edge_q),
    .quot_o     (row_q)
  );

  logic  vd_q [QW];
  side_t sd_q [QW];

  for (genvar s = 0; s < QW; s++) begin : g_side
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vd_q[s] <= 1'b0;
      else         vd_q[s] <= (s == 0) ? v3_q : vd_q[(s == 0) ? 0 : s-1];
    end
    always_ff @(posedge clk_i) begin
      sd_q[s] <= (s == 0) ? side3_q : sd_q[(s == 0) ? 0 : s-1];
    end
  end

  // Final stage: cell count test, linear index, result register.
  side_t          sf;
  logic [NW-1:0]  nx, ny;
  logic [IW-1:0]  idx_full;
  logic [IW+19:0] idx_ext;
  logic [QW+9:0]  col_ext, row_ext;
  reject_code_e   code_f;
  result_t        res_d;
  logic           res_valid_q;
  result_t        res_q;

  always_comb begin
    sf       = sd_q[QW-1];
    nx       = (32'(cells_x_q) > MAX_CELLS_PER_AXIS) ? NW'(MAX_CELLS_PER_AXIS)
                                                     : NW'(cells_x_q);
    ny       = (32'(cells_y_q) > MAX_CELLS_PER_AXIS) ? NW'(MAX_CELLS_PER_AXIS)
                                                     : NW'(cells_y_q);
    idx_full = IW'(row_q) * IW'(nx) + IW'(col_q);
    idx_ext  = {20'd0, idx_full};
    col_ext  = {10'd0, col_q};
    row_ext  = {10'd0, row_q};
    if (sf.code != RC_KEPT) begin
      code_f = sf.code;
    end else if (sf.ovf_x || sf.ovf_y || NW'(col_q) >= nx || NW'(row_q) >= ny) begin
      code_f = RC_OUTSIDE;
    end else begin
      code_f = RC_KEPT;
    end
    res_d             = '0;
    res_d.reject_code = code_f;
    if (code_f == RC_KEPT) begin
      res_d.kept            = 1'b1;
      res_d.cell_col        = col_ext[9:0];
      res_d.cell_row        = row_ext[9:0];
      res_d.cell_index      = idx_ext[19:0];
      res_d.intensity_value = sf.iv;
      res_d.height_value    = sf.hv;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) res_valid_q <= 1'b0;
    else         res_valid_q <= vd_q[QW-1];
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  // Every accepted transaction yields a result strobe.
  `PGCM_ASSERT_DLY(a_latency, clk_i, rst_ni, start && !busy, LATENCY, result_valid_o)
  // The kept flag agrees with the reject code.
  `PGCM_ASSERT_IMP(a_kept_code, clk_i, rst_ni, result_valid_o,
                   result_o.kept == (result_o.reject_code == RC_KEPT))
  // A rejected point has all-zero cell and value fields; checked on index, column and height.
  `PGCM_ASSERT_IMP(a_reject_zero, clk_i, rst_ni, result_valid_o && !result_o.kept,
                   result_o.cell_index == 20'd0 && result_o.cell_col == 10'd0 &&
                   result_o.height_value == 8'sd0)

endmodule

// File: design/pgcm_divider.sv
// Pipelined restoring divider, one quotient bit per register stage.
module pgcm_divider #(
  parameter int QW = 10,
  parameter int CW = 26
) (
  input  logic          clk_i,
  input  logic [23:0]   dividend_i,
  input  logic [15:0]   divisor_i,
  output logic [QW-1:0] quot_o
);

  logic [CW-1:0] rem_q [QW];
  logic [QW-1:0] quot_q [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [CW-1:0] rem_in;
    logic [QW-1:0] quot_in;
    logic [CW-1:0] trial;
    if (s == 0) begin : g_first
      assign rem_in  = CW'(dividend_i);
      assign quot_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign quot_in = quot_q[s-1];
    end
    // Divisor aligned to the quotient bit of this stage.
    assign trial = CW'(divisor_i) << (QW - 1 - s);

    always_ff @(posedge clk_i) begin
      if (rem_in >= trial) begin
        rem_q[s]  <= rem_in - trial;
        quot_q[s] <= quot_in | (QW'(1) << (QW - 1 - s));
      end else begin
        rem_q[s]  <= rem_in;
        quot_q[s] <= quot_in;
      end
    end
  end

  assign quot_o = quot_q[QW-1];

endmodule

// File: tb/point_to_grid_cell_mapper_tb.sv
// Self-checking testbench for the point to grid cell mapper.
`timescale 1ns / 100ps

module point_to_grid_cell_mapper_tb;
  import pgcm_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  // Settling time after the last result, with headroom beyond the pipeline depth.
  localparam int SETTLE_CYCLES  = 24;
  localparam int MAX_AXIS       = 1024;
  localparam int HEIGHT_LO      = 13;
  localparam int HEIGHT_HI      = 384;

  // Scoreboard: holds its own copy of the registers, predicts the cell
  // result for each accepted point and checks results in arrival order.
  class grid_cell_scoreboard;
    logic [15:0]        cell_edge;
    logic signed [23:0] grid_left;
    logic signed [23:0] grid_top;
    logic [10:0]        cells_x;
    logic [10:0]        cells_y;
    logic signed [15:0] intensity_gain;
    logic signed [15:0] height_gain;
    result_t            expected_cells[$];
    int                 mismatches;

    function void reset_registers();
      cell_edge      = 16'd128;
      grid_left      = -24'sd2560;
      grid_top       = 24'sd2560;
      cells_x        = 11'd40;
      cells_y        = 11'd40;
      intensity_gain = 16'sd256;
      height_gain    = 16'sd256;
      mismatches     = 0;
    endfunction

    function void write_register(cfg_reg_e idx, logic [23:0] data);
      case (idx)
        CFG_CELL_EDGE:      cell_edge      = data[15:0];
        CFG_GRID_LEFT:      grid_left      = data;
        CFG_GRID_TOP:       grid_top       = data;
        CFG_CELLS_X:        cells_x        = data[10:0];
        CFG_CELLS_Y:        cells_y        = data[10:0];
        CFG_INTENSITY_GAIN: intensity_gain = data[15:0];
        CFG_HEIGHT_GAIN:    height_gain    = data[15:0];
        default: ;
      endcase
    endfunction

    // Product of Q.8 value and Q8.8 gain, truncated toward zero, saturated.
    function logic signed [7:0] scale_to_int8(longint v, longint g);
      longint prod, mag, q;
      prod = v * g;
      mag  = (prod < 0) ? -prod : prod;
      q    = mag / 65536;
      if (prod < 0) q = -q;
      if (q > 127) q = 127;
      if (q < -128) q = -128;
      return q[7:0];
    endfunction

    function longint axis_cells(logic [10:0] n);
      return (n > MAX_AXIS) ? MAX_AXIS : longint'(n);
    endfunction

    function void note_point(point_t p);
      result_t r;
      longint  x, y, z, inten, dx, dy, nx, ny, c, rw;
      x     = p.point_x;
      y     = p.point_y;
      z     = p.point_z;
      inten = p.intensity_present ? longint'(p.point_intensity) : 0;
      r     = '0;
      r.reject_code = RC_KEPT;
      if (((x < 0) ? -x : x) <= NEAR_LIMIT) begin
        r.reject_code = RC_NEAR;
      end else if (z < HEIGHT_LO || z > HEIGHT_HI) begin
        r.reject_code = RC_HEIGHT;
      end else if (x * x + y * y > longint'(FAR_LIMIT_SQ)) begin
        r.reject_code = RC_FAR;
      end else begin
        dx = x - longint'(grid_left);
        dy = longint'(grid_top) - y;
        nx = axis_cells(cells_x);
        ny = axis_cells(cells_y);
        if (cell_edge == 0 || dx <= 0 || dy <= 0) begin
          r.reject_code = RC_OUTSIDE;
        end else begin
          c  = dx / cell_edge;
          rw = dy / cell_edge;
          if (c >= nx || rw >= ny) begin
            r.reject_code = RC_OUTSIDE;
          end else begin
            r.cell_col        = c[9:0];
            r.cell_row        = rw[9:0];
            r.cell_index      = 20'(rw * nx + c);
            r.intensity_value = scale_to_int8(inten, intensity_gain);
            r.height_value    = scale_to_int8(z, height_gain);
          end
        end
      end
      r.kept = (r.reject_code == RC_KEPT);
      expected_cells.push_back(r);
    endfunction

    task report(string field, longint got, longint want);
      $display("%0t: %s got %0d expected %0d", $time, field, got, want);
      mismatches++;
    endtask

    task check_result(result_t got);
      result_t want;
      if (expected_cells.size() == 0) begin
        report("result with no point outstanding", 1, 0);
        return;
      end
      want = expected_cells.pop_front();
      if (got.kept !== want.kept) report("kept", got.kept, want.kept);
      if (got.reject_code !== want.reject_code)
        report("reject_code", got.reject_code, want.reject_code);
      if (got.cell_col !== want.cell_col) report("cell_col", got.cell_col, want.cell_col);
      if (got.cell_row !== want.cell_row) report("cell_row", got.cell_row, want.cell_row);
      if (got.cell_index !== want.cell_index)
        report("cell_index", got.cell_index, want.cell_index);
      if (got.intensity_value !== want.intensity_value)
        report("intensity_value", got.intensity_value, want.intensity_value);
      if (got.height_value !== want.height_value)
        report("height_value", got.height_value, want.height_value);
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  point_t      point_i;
  logic        result_valid_o;
  result_t     result_o;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [23:0] cfg_data_i;

  grid_cell_scoreboard sb;
  int burst_left;
  int idle_cycles;

  point_to_grid_cell_mapper u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .point_i        (point_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Note each accepted point; values read here are the pre-edge ones.
  always @(posedge clk_i) begin
    if (rst_ni && start && !busy) sb.note_point(point_i);
  end

  // Results cannot be held off: check every strobed one.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) sb.check_result(result_o);
  end

  // Watchdog: give up after a long stretch with no transaction at all.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Present one point and hold it until accepted; then either keep start
  // high for the next point of the burst or drop it for a random gap.
  task automatic send_point(point_t p);
    start   <= 1'b1;
    point_i <= p;
    do @(posedge clk_i); while (busy);
    if (burst_left == 0) begin
      burst_left = $urandom_range(0, 40);
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Wait until every outstanding point has produced its result, then let
  // the pipeline settle.
  task automatic drain();
    start <= 1'b0;
    while (sb.expected_cells.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One write per call, with the enable dropped and an idle wait after it so
  // that back to back writes never drive the enable twice in one step.
  task automatic write_register(cfg_reg_e idx, logic [23:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.write_register(idx, data);
    @(posedge clk_i);
  endtask

  function automatic point_t make_point(longint x, longint y, longint z,
                                        longint inten, bit has_i);
    point_t p;
    p.point_x           = x[23:0];
    p.point_y           = y[23:0];
    p.point_z           = z[23:0];
    p.point_intensity   = inten[23:0];
    p.intensity_present = has_i;
    return p;
  endfunction

  // Mostly points aimed at the grid within the height band; the rest noise.
  function automatic point_t random_point();
    point_t p;
    longint span_x, span_y, cs;
    p.point_x           = 24'($urandom);
    p.point_y           = 24'($urandom);
    p.point_z           = 24'($urandom);
    p.point_intensity   = 24'($urandom);
    p.intensity_present = 1'($urandom);
    if ($urandom_range(0, 9) < 8) begin
      cs     = (sb.cell_edge == 0) ? 1 : sb.cell_edge;
      span_x = cs * sb.axis_cells(sb.cells_x);
      span_y = cs * sb.axis_cells(sb.cells_y);
      if (span_x > 12000) span_x = 12000;
      if (span_y > 12000) span_y = 12000;
      p.point_x = 24'(longint'(sb.grid_left) + $urandom_range(0, 32'(span_x + 2)) - 1);
      p.point_y = 24'(longint'(sb.grid_top) - $urandom_range(0, 32'(span_y + 2)) + 1);
      if ($urandom_range(0, 9) != 0)
        p.point_z = 24'($urandom_range(HEIGHT_LO - 1, HEIGHT_HI + 1));
      if ($urandom_range(0, 1) == 0)
        p.point_intensity = 24'(int'($urandom_range(0, 4000)) - 2000);
    end
    return p;
  endfunction

  function automatic logic [23:0] pick(logic [23:0] a, logic [23:0] b,
                                       logic [23:0] c, logic [23:0] d);
    case ($urandom_range(0, 3))
      0: return a;
      1: return b;
      2: return c;
      default: return d;
    endcase
  endfunction

  initial begin
    sb = new();
    sb.reset_registers();
    burst_left = 0;
    rst_ni     = 1'b0;
    start      = 1'b0;
    point_i    = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CFG_CELL_EDGE;
    cfg_data_i = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed points against the reset grid (40 x 40 cells of 0.5 m).
    send_point(make_point(0, 100, 100, 50, 1));           // near origin
    send_point(make_point(2, 100, 100, 50, 1));
    send_point(make_point(-2, 100, 100, 50, 1));
    send_point(make_point(3, 100, 100, 50, 1));           // just off origin
    send_point(make_point(300, 100, 12, 50, 1));          // below height band
    send_point(make_point(300, 100, 13, 50, 1));          // band lower edge
    send_point(make_point(300, 100, 384, 50, 1));         // band upper edge
    send_point(make_point(300, 100, 385, 50, 1));         // above band
    send_point(make_point(5120, 0, 100, 50, 1));          // exactly 20 m
    send_point(make_point(5120, 1, 100, 50, 1));          // just beyond 20 m
    send_point(make_point(-2560, 100, 100, 50, 1));       // on left edge
    send_point(make_point(-2559, 100, 100, 50, 1));       // first column
    send_point(make_point(2559, -2559, 100, 50, 1));      // last cell
    send_point(make_point(2560, 100, 100, 50, 1));        // on right edge
    send_point(make_point(100, 2560, 100, 50, 1));        // on top edge
    send_point(make_point(100, -2560, 100, 50, 1));       // on bottom edge
    send_point(make_point(8388607, 8388607, 8388607, 8388607, 1));
    send_point(make_point(-8388608, -8388608, -8388608, -8388608, 1));
    send_point(make_point(500, 500, 200, 8388607, 1));    // intensity saturates
    send_point(make_point(500, 500, 200, -8388608, 1));
    send_point(make_point(500, 500, 200, 8388607, 0));    // intensity ignored
    send_point(make_point(-500, -500, 13, -300, 1));
    drain();

    // Phases of register settings, extremes included, each with random points.
    for (int phase = 0; phase < 9; phase++) begin
      if (phase > 0) begin
        write_register(CFG_CELL_EDGE,
                       pick(24'd1, 24'd65535, 24'd0, 24'($urandom_range(16, 600))));
        write_register(CFG_GRID_LEFT,
                       pick(24'h800000, 24'h7FFFFF, 24'(-$urandom_range(0, 6000)),
                            24'(-$urandom_range(0, 6000))));
        write_register(CFG_GRID_TOP,
                       pick(24'h7FFFFF, 24'h800000, 24'($urandom_range(0, 6000)),
                            24'($urandom_range(0, 6000))));
        write_register(CFG_CELLS_X,
                       pick(24'd0, 24'd2047, 24'd1024, 24'($urandom_range(1, 1100))));
        write_register(CFG_CELLS_Y,
                       pick(24'd1, 24'd2047, 24'd1023, 24'($urandom_range(1, 1100))));
        write_register(CFG_INTENSITY_GAIN,
                       pick(24'hFF8000, 24'h007FFF, 24'(16'($urandom)), 24'd256));
        write_register(CFG_HEIGHT_GAIN,
                       pick(24'hFF8000, 24'h007FFF, 24'(16'($urandom)), 24'd256));
        // Keep a usable grid in most phases so kept points stay common.
        if (phase % 3 != 0) begin
          write_register(CFG_CELL_EDGE, 24'($urandom_range(4, 300)));
          write_register(CFG_GRID_LEFT, 24'(-$urandom_range(0, 6000)));
          write_register(CFG_GRID_TOP, 24'($urandom_range(0, 6000)));
        end
      end
      repeat (100) send_point(random_point());
      // Pause the sender until all outstanding results are in.
      drain();
    end

    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
